// ----- rtl/cbe_pkg.sv -----
// Shared types, constants and the character pattern table for the Code 39 bar encoder.
`default_nettype none

package cbe_pkg;

    localparam int NARROW_W = 16;
    localparam int HEIGHT_W = 16;
    localparam int COORD_W  = 32;
    localparam int RWIDTH_W = 17;
    localparam int PAT_W    = 9;
    localparam int BARS     = 5;
    localparam int QUEUE_DEPTH = 2;

    // Input kinds
    localparam logic [1:0] KIND_BEGIN = 2'd0;
    localparam logic [1:0] KIND_CHAR  = 2'd1;
    localparam logic [1:0] KIND_END   = 2'd2;

    // Configuration register indexes
    localparam logic REG_NARROW     = 1'b0;
    localparam logic REG_BAR_HEIGHT = 1'b1;

    localparam logic [NARROW_W-1:0] NARROW_RESET = 16'd100;
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 16'd1000;

    localparam logic [RWIDTH_W-1:0] RWIDTH_MAX = 17'h1FFFF;

    // Nine elements, first element in bit 8, a set bit is wide
    localparam logic [PAT_W-1:0] PAT_STAR = 9'h094;
    localparam logic [PAT_W-1:0] PAT_DASH = 9'h085;

    typedef struct packed {
        logic [1:0]                 kind;
        logic signed [COORD_W-1:0]  origin_x;
        logic signed [COORD_W-1:0]  origin_y;
        logic [15:0]                char_code;
    } t_in;

    typedef struct packed {
        logic signed [COORD_W-1:0]  rect_x;
        logic signed [COORD_W-1:0]  rect_y;
        logic [RWIDTH_W-1:0]        rect_width;
        logic [HEIGHT_W-1:0]        rect_height;
        logic                       last;
    } t_out;

    // One classified item waiting for the bar generator
    typedef struct packed {
        logic                       is_begin;
        logic [COORD_W-1:0]         origin_x;
        logic [COORD_W-1:0]         origin_y;
        logic [PAT_W-1:0]           pattern;
    } t_item;

    function automatic logic [PAT_W-1:0] pattern_of(input logic [15:0] code);
        logic [PAT_W-1:0] pat;
        unique case (code)
            16'h0041: pat = 9'h109;
            16'h0042: pat = 9'h049;
            16'h0043: pat = 9'h148;
            16'h0044: pat = 9'h019;
            16'h0045: pat = 9'h118;
            16'h0046: pat = 9'h058;
            16'h0047: pat = 9'h00D;
            16'h0048: pat = 9'h10C;
            16'h0049: pat = 9'h04C;
            16'h004A: pat = 9'h01C;
            16'h004B: pat = 9'h103;
            16'h004C: pat = 9'h043;
            16'h004D: pat = 9'h142;
            16'h004E: pat = 9'h013;
            16'h004F: pat = 9'h112;
            16'h0050: pat = 9'h052;
            16'h0051: pat = 9'h007;
            16'h0052: pat = 9'h106;
            16'h0053: pat = 9'h046;
            16'h0054: pat = 9'h016;
            16'h0055: pat = 9'h181;
            16'h0056: pat = 9'h0C1;
            16'h0057: pat = 9'h1C0;
            16'h0058: pat = 9'h091;
            16'h0059: pat = 9'h190;
            16'h005A: pat = 9'h0D0;
            16'h0030: pat = 9'h034;
            16'h0031: pat = 9'h121;
            16'h0032: pat = 9'h061;
            16'h0033: pat = 9'h160;
            16'h0034: pat = 9'h031;
            16'h0035: pat = 9'h130;
            16'h0036: pat = 9'h070;
            16'h0037: pat = 9'h025;
            16'h0038: pat = 9'h124;
            16'h0039: pat = 9'h064;
            16'h0020: pat = 9'h0C4;
            16'h002D: pat = PAT_DASH;
            16'h0024: pat = 9'h0A8;
            16'h0025: pat = 9'h02A;
            16'h002E: pat = 9'h184;
            16'h002F: pat = 9'h0A2;
            16'h002B: pat = 9'h08A;
            // unsupported characters, the asterisk included, draw as a dash
            default:  pat = PAT_DASH;
        endcase
        return pat;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/code39_bar_encoder_unit.sv -----
// Top level of the Code 39 bar encoder: front end, item queue and bar generator.
`default_nettype none

// Each accepted transaction of kind begin, character or end yields five bar
// rectangles, left to right, one per clock on the output channel while it is
// not stalled; kind 3 is taken and yields nothing. The bar generator emits one
// rectangle per cycle unless the output is stalled, with results of a steady
// stream following each other with no gap between items. A two-entry queue
// lets the input side take items while the generator works or the output is
// stalled; an accepted item is written into the queue and, when the generator
// is free, popped and its first rectangle loaded into the output register. Bar
// widths are the narrow width or the narrow width times WIDE_RATIO, clipped to
// 131071 on the output while the cursor advances by the full width.
// Configuration writes are taken at once and must be done while idle.
module code39_bar_encoder_unit
    import cbe_pkg::*;
#(
    parameter int WIDE_RATIO = 2
)(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic                  i_cfg_idx,
    input  wire logic [NARROW_W-1:0]   i_cfg_data,
    input  wire logic                  i_in_valid,
    input  wire t_in                   i_in_data,
    output logic                       o_in_stall,
    output logic                       o_out_valid,
    output t_out                       o_out_data,
    input  wire logic                  i_out_stall
);

    logic   q_push;
    t_item  q_in_item;
    logic   q_full;
    logic   q_pop;
    logic   q_valid;
    t_item  q_out_item;

    cbe_front u_front (
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .o_in_stall (o_in_stall),
        .i_q_full   (q_full),
        .o_q_push   (q_push),
        .o_q_item   (q_in_item)
    );

    cbe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (q_in_item),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_item  (q_out_item)
    );

    cbe_back #(
        .WIDE_RATIO (WIDE_RATIO)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_q_valid   (q_valid),
        .i_q_item    (q_out_item),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

endmodule

`default_nettype wire

// ----- rtl/cbe_front.sv -----
// Front end: accepts input transactions, decodes the kind and looks up the bar pattern.
`default_nettype none

module cbe_front
    import cbe_pkg::*;
(
    input  wire logic  i_in_valid,
    input  wire t_in   i_in_data,
    output logic       o_in_stall,
    input  wire logic  i_q_full,
    output logic       o_q_push,
    output t_item      o_q_item
);

    logic  accept;
    logic  keep;

    assign o_in_stall = i_q_full;
    assign accept     = i_in_valid && !i_q_full;

    always_comb begin
        keep              = 1'b1;
        o_q_item.is_begin = 1'b0;
        o_q_item.origin_x = i_in_data.origin_x;
        o_q_item.origin_y = i_in_data.origin_y;
        o_q_item.pattern  = PAT_STAR;
        unique case (i_in_data.kind)
            KIND_BEGIN: begin
                o_q_item.is_begin = 1'b1;
            end
            KIND_CHAR: begin
                o_q_item.pattern = pattern_of(i_in_data.char_code);
            end
            KIND_END: begin
                o_q_item.pattern = PAT_STAR;
            end
            // unused kind: take the transaction and drop it
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    assign o_q_push = accept && keep;

endmodule

`default_nettype wire

// ----- rtl/cbe_queue.sv -----
// Short FIFO of classified items between the front end and the bar generator.
`default_nettype none

module cbe_queue
    import cbe_pkg::*;
#(
    parameter int DEPTH = 2
)(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_item i_item,
    output logic       o_full,
    input  wire logic  i_pop,
    output logic       o_valid,
    output t_item      o_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_item              r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr, n_wr;
    logic [PTR_W-1:0]   r_rd, n_rd;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               do_push;
    logic               do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (do_push) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (do_pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/cbe_back.sv -----
// Bar generator: walks each pattern one bar per unstalled cycle; drives the output.
`default_nettype none

module cbe_back
    import cbe_pkg::*;
#(
    parameter int WIDE_RATIO = 2
)(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic                  i_cfg_idx,
    input  wire logic [NARROW_W-1:0]   i_cfg_data,
    input  wire logic                  i_q_valid,
    input  wire t_item                 i_q_item,
    output logic                       o_q_pop,
    output logic                       o_out_valid,
    output t_out                       o_out_data,
    input  wire logic                  i_out_stall
);

    localparam int WW    = $clog2((2 ** NARROW_W - 1) * WIDE_RATIO + 1);
    localparam int SW    = WW + 1;
    localparam int IDX_W = $clog2(BARS);
    localparam logic [IDX_W-1:0] LAST_BAR = IDX_W'(BARS - 1);
    localparam logic [WW-1:0]    SAT      = WW'(RWIDTH_MAX);

    logic [NARROW_W-1:0]  r_narrow, n_narrow;
    logic [HEIGHT_W-1:0]  r_height, n_height;
    logic                 r_busy, n_busy;
    logic [PAT_W-1:0]     r_pat, n_pat;
    logic [IDX_W-1:0]     r_idx, n_idx;
    logic [COORD_W-1:0]   r_cursor, n_cursor;
    logic [COORD_W-1:0]   r_base, n_base;
    logic                 r_out_valid, n_out_valid;
    t_out                 r_out, n_out;

    logic                 can_emit;
    logic                 emit;
    logic [PAT_W-1:0]     cur_pat;
    logic [IDX_W-1:0]     cur_idx;
    logic [COORD_W-1:0]   cur_x;
    logic [COORD_W-1:0]   cur_base;
    logic [WW-1:0]        narrow_ext;
    logic [WW-1:0]        wide;
    logic [WW-1:0]        bar_w;
    logic [WW-1:0]        space_w;
    logic [SW-1:0]        step;
    logic                 is_last;

    assign can_emit = !r_out_valid || !i_out_stall;
    assign emit     = (r_busy || i_q_valid) && can_emit;
    assign o_q_pop  = !r_busy && i_q_valid && can_emit;

    // Between items the head of the queue feeds the generator directly
    assign cur_pat  = r_busy ? r_pat : i_q_item.pattern;
    assign cur_idx  = r_busy ? r_idx : '0;
    assign cur_x    = (!r_busy && i_q_item.is_begin) ? i_q_item.origin_x : r_cursor;
    assign cur_base = (!r_busy && i_q_item.is_begin) ? i_q_item.origin_y : r_base;

    assign narrow_ext = WW'(r_narrow);
    assign wide       = narrow_ext * WW'(WIDE_RATIO);
    assign is_last    = (cur_idx == LAST_BAR);
    assign bar_w      = cur_pat[PAT_W-1] ? wide : narrow_ext;
    // After the last bar the cursor skips the inter-character gap
    assign space_w    = (!is_last && cur_pat[PAT_W-2]) ? wide : narrow_ext;
    assign step       = SW'(bar_w) + SW'(space_w);

    always_comb begin
        n_narrow = r_narrow;
        n_height = r_height;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_NARROW:     n_narrow = i_cfg_data;
                REG_BAR_HEIGHT: n_height = i_cfg_data;
                default:        n_narrow = r_narrow;
            endcase
        end
    end

    always_comb begin
        n_busy      = r_busy;
        n_pat       = r_pat;
        n_idx       = r_idx;
        n_cursor    = r_cursor;
        n_base      = r_base;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (emit) begin
            n_out.rect_x      = cur_x;
            n_out.rect_y      = cur_base;
            n_out.rect_width  = (bar_w > SAT) ? RWIDTH_MAX : RWIDTH_W'(bar_w);
            n_out.rect_height = r_height;
            n_out.last        = is_last;
            n_out_valid       = 1'b1;
            n_cursor          = cur_x + COORD_W'(step);
            n_base            = cur_base;
            n_busy            = !is_last;
            // advance to the next bar/space pair
            n_pat             = {cur_pat[PAT_W-3:0], 2'b00};
            n_idx             = cur_idx + 1'b1;
        end else if (can_emit) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_narrow    <= NARROW_RESET;
            r_height    <= HEIGHT_RESET;
            r_busy      <= 1'b0;
            r_idx       <= '0;
            r_cursor    <= '0;
            r_base      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_narrow    <= n_narrow;
            r_height    <= n_height;
            r_busy      <= n_busy;
            r_idx       <= n_idx;
            r_cursor    <= n_cursor;
            r_base      <= n_base;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pat <= n_pat;
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_idx != '0 && r_idx <= LAST_BAR))
        else $error("bar index out of range while busy");

    a_last_ends_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && is_last) |=> !r_busy)
        else $error("generator still busy after the last bar");

    a_busy_from_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_busy) |-> $past(o_q_pop))
        else $error("generator started without taking a queued item");

endmodule

`default_nettype wire
